[src/tms_pkg.sv]
// ---------------------------------------------------------------------------
// tms_pkg
// Shared types and constants for the tracker module header sniffer.
// ---------------------------------------------------------------------------
package tms_pkg;

  localparam int unsigned POS_W = 11;

  localparam logic [POS_W-1:0] POS_MAX    = 11'd2047;
  localparam logic [POS_W-1:0] TAG_OFFSET = 11'd1080;
  localparam logic [POS_W-1:0] TAG_END    = 11'd1084;
  localparam logic [POS_W-1:0] VER_LO_POS = 11'd58;
  localparam logic [POS_W-1:0] VER_HI_POS = 11'd59;
  localparam logic [POS_W-1:0] B12_POS    = 11'd12;
  localparam logic [POS_W-1:0] B68_POS    = 11'd68;
  localparam logic [POS_W-1:0] NAME_BASE  = 11'd20;

  localparam logic [POS_W-1:0] ZIRC_LEN = 11'd8;
  localparam logic [POS_W-1:0] XM_LEN   = 11'd17;
  localparam logic [POS_W-1:0] MXM_LEN  = 11'd4;
  localparam logic [POS_W-1:0] MXM_MIN  = 11'd3;

  localparam logic [4:0] NAME_COUNT   = 5'd31;
  localparam logic [4:0] NAME_LOW_CNT = 5'd15;
  localparam logic [4:0] NAME_LEN     = 5'd21;
  localparam logic [4:0] SLOT_LAST    = 5'd29;

  localparam logic [31:0] TAG_MK      = 32'h2E4B2E4D;
  localparam logic [15:0] XM_MIN_VER  = 16'h0104;

  localparam logic [1:0] EXT_WOW = 2'd1;
  localparam logic [1:0] EXT_MOD = 2'd2;

  localparam logic [2:0] PREFIX_ALL  = 3'b111;
  localparam logic [1:0] QUALITY_ALL = 2'b11;
  localparam logic [1:0] QUALITY_LOW = 2'b01;

  // "ziRCONia"
  localparam logic [7:0] MARK_ZIRC [0:7] = '{
    8'h7A, 8'h69, 8'h52, 8'h43, 8'h4F, 8'h4E, 8'h69, 8'h61
  };

  // "Extended Module: "
  localparam logic [7:0] MARK_XM [0:16] = '{
    8'h45, 8'h78, 8'h74, 8'h65, 8'h6E, 8'h64, 8'h65, 8'h64, 8'h20,
    8'h4D, 8'h6F, 8'h64, 8'h75, 8'h6C, 8'h65, 8'h3A, 8'h20
  };

  // "MXM" and a zero
  localparam logic [7:0] MARK_MXM [0:3] = '{8'h4D, 8'h58, 8'h4D, 8'h00};

  typedef enum logic [3:0] {
    FMT_UNKNOWN    = 4'd0,
    FMT_COMPRESSED = 4'd1,
    FMT_WOW        = 4'd2,
    FMT_MOD        = 4'd3,
    FMT_XM         = 4'd4,
    FMT_MXM        = 4'd5,
    FMT_MOD31      = 4'd6,
    FMT_MOD15      = 4'd7,
    FMT_XM_OLD     = 4'd8
  } fmt_class_t;

  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } in_word_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [31:0]      tag;
    logic [2:0]       prefix;
    logic [15:0]      version;
    logic [7:0]       b12;
    logic [7:0]       b68;
    logic [1:0]       quality;
  } hdr_info_t;

endpackage

[src/tracker_module_header_sniffer.sv]
// ---------------------------------------------------------------------------
// tracker_module_header_sniffer
// Identifies a tracker music module from its header bytes.
// ---------------------------------------------------------------------------
// Header bytes enter one word per cycle from file offset 0; the word with
// tlast set closes the header and yields one result word by way of the input
// register and the result register, and the header state is cleared for the
// next file. Each word passes through an input register and the header state
// update; the final word also passes the format decision and a result
// register. The stream runs at one word a cycle; input stalls only while a
// result waits at the output and the held word is a final one.
module tracker_module_header_sniffer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,      // extension_kind
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,     // header_byte
  input  logic        s_axis_tlast,     // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata      // format_class[3:0], channel_count[11:4], zero
);
  import tms_pkg::*;

  logic       ext_kind;
  logic [1:0] ext_kind_q;
  logic       held_valid;
  in_word_t   held_word;
  in_word_t   s_word;
  logic       advance;
  hdr_info_t  info;
  fmt_class_t fmt;
  logic [7:0] channels;
  logic [3:0] out_fmt;
  logic [7:0] out_ch;

  assign ext_kind = cfg_wr_en;
  assign s_word   = '{last: s_axis_tlast, data: s_axis_tdata};
  assign advance  = held_valid && (!held_word.last || !m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      ext_kind_q <= '0;
    end else if (ext_kind) begin
      ext_kind_q <= cfg_wr_data;
    end
  end

  tms_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_axis_tvalid),
    .s_ready    (s_axis_tready),
    .s_word     (s_word),
    .advance    (advance),
    .held_valid (held_valid),
    .held_word  (held_word)
  );

  tms_tracker u_tracker (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .word (held_word),
    .info (info)
  );

  tms_classify u_classify (
    .info     (info),
    .ext_kind (ext_kind_q),
    .fmt      (fmt),
    .channels (channels)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance && held_word.last) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && held_word.last) begin
      out_fmt <= fmt;
      out_ch  <= channels;
    end
  end

  assign m_axis_tdata = {4'd0, out_ch, out_fmt};

endmodule

[src/tms_in_stage.sv]
// ---------------------------------------------------------------------------
// tms_in_stage
// Input register for header words; takes a new word when it holds none or
// whenever the held word moves on in the same cycle.
// ---------------------------------------------------------------------------
module tms_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_valid,
  output logic              s_ready,
  input  tms_pkg::in_word_t s_word,
  input  logic              advance,
  output logic              held_valid,
  output tms_pkg::in_word_t held_word
);
  import tms_pkg::*;

  assign s_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (s_ready) begin
      held_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      held_word <= s_word;
    end
  end

endmodule

[src/tms_tracker.sv]
// ---------------------------------------------------------------------------
// tms_tracker
// Header state: position, tag, prefix matches, sampled bytes and the
// sample name quality scan. Shows the state as it stands after the word.
// ---------------------------------------------------------------------------
module tms_tracker (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  tms_pkg::in_word_t  word,
  output tms_pkg::hdr_info_t info
);
  import tms_pkg::*;

  hdr_info_t  hdr;
  hdr_info_t  hdr_next;
  logic [4:0] slot_index;
  logic [4:0] slot_index_next;
  logic [4:0] slot_offset;
  logic [4:0] slot_offset_next;
  logic       slot_ended;
  logic       slot_ended_next;

  always_comb begin
    logic [7:0] b;
    b                = word.data;
    hdr_next         = hdr;
    slot_index_next  = slot_index;
    slot_offset_next = slot_offset;
    slot_ended_next  = slot_ended;

    if (hdr.pos < ZIRC_LEN && b != MARK_ZIRC[hdr.pos[2:0]]) hdr_next.prefix[0] = 1'b0;
    if (hdr.pos < XM_LEN && b != MARK_XM[hdr.pos[4:0]]) hdr_next.prefix[1] = 1'b0;
    if (hdr.pos < MXM_LEN && b != MARK_MXM[hdr.pos[1:0]]) hdr_next.prefix[2] = 1'b0;

    if (hdr.pos >= TAG_OFFSET && hdr.pos < TAG_END) begin
      hdr_next.tag = hdr.tag | ({24'd0, b} << {hdr.pos[1:0], 3'b000});
    end
    if (hdr.pos == VER_LO_POS) hdr_next.version[7:0]  = hdr.version[7:0] | b;
    if (hdr.pos == VER_HI_POS) hdr_next.version[15:8] = hdr.version[15:8] | b;
    if (hdr.pos == B12_POS) hdr_next.b12 = b;
    if (hdr.pos == B68_POS) hdr_next.b68 = b;

    // empty title
    if (hdr.pos == '0 && b == 8'd0) hdr_next.quality = 2'b00;

    if (hdr.pos >= NAME_BASE && slot_index < NAME_COUNT) begin
      if (slot_offset < NAME_LEN && !slot_ended) begin
        if (b == 8'd0) begin
          slot_ended_next = 1'b1;
        end else if (b < 8'h20 || b >= 8'h80) begin
          if (slot_index < NAME_LOW_CNT) begin
            hdr_next.quality = 2'b00;
          end else begin
            hdr_next.quality = {1'b0, hdr.quality[0]};
          end
        end
      end
      if (slot_offset == SLOT_LAST) begin
        slot_offset_next = '0;
        slot_index_next  = slot_index + 5'd1;
        slot_ended_next  = 1'b0;
      end else begin
        slot_offset_next = slot_offset + 5'd1;
      end
    end

    if (hdr.pos != POS_MAX) hdr_next.pos = hdr.pos + 11'd1;
  end

  assign info = hdr_next;

  always_ff @(posedge clk) begin
    if (rst || (step && word.last)) begin
      hdr.pos     <= '0;
      hdr.tag     <= '0;
      hdr.prefix  <= PREFIX_ALL;
      hdr.version <= '0;
      hdr.b12     <= '0;
      hdr.b68     <= '0;
      hdr.quality <= QUALITY_ALL;
      slot_index  <= '0;
      slot_offset <= '0;
      slot_ended  <= 1'b0;
    end else if (step) begin
      hdr         <= hdr_next;
      slot_index  <= slot_index_next;
      slot_offset <= slot_offset_next;
      slot_ended  <= slot_ended_next;
    end
  end

endmodule

[src/tms_classify.sv]
// ---------------------------------------------------------------------------
// tms_classify
// Format decision from the header state after the final word.
// ---------------------------------------------------------------------------
module tms_classify (
  input  tms_pkg::hdr_info_t  info,
  input  logic [1:0]          ext_kind,
  output tms_pkg::fmt_class_t fmt,
  output logic [7:0]          channels
);
  import tms_pkg::*;

  function automatic logic [7:0] tag_channels(input logic [31:0] t);
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] n;
    lo = t[7:0] - 8'h30;
    hi = t[15:8] - 8'h30;
    n  = ({4'd0, lo[3:0]} * 8'd10) + {4'd0, hi[3:0]};
    if (t == TAG_MK || t == 32'h214B214D || t == 32'h2E542E4E || t == 32'h34544C46) begin
      return 8'd4;
    end
    if (t[31:8] == 24'h4E4843 && t[7:0] >= 8'h31 && t[7:0] <= 8'h39) begin
      return lo;
    end
    if (t[31:16] == 16'h4843 && t[7:0] >= 8'h30 && t[7:0] <= 8'h39 &&
        t[15:8] >= 8'h30 && t[15:8] <= 8'h39 && n >= 8'd10 && n <= 8'd32) begin
      return n;
    end
    return 8'd0;
  endfunction

  logic [7:0] tag_ch;

  assign tag_ch = tag_channels(info.tag);

  always_comb begin
    fmt      = FMT_UNKNOWN;
    channels = 8'd0;
    priority if (info.prefix[0] && info.pos >= ZIRC_LEN) begin
      fmt = FMT_COMPRESSED;
    end else if (ext_kind == EXT_WOW && info.tag == TAG_MK) begin
      fmt = FMT_WOW;
    end else if (tag_ch != 8'd0) begin
      fmt      = FMT_MOD;
      channels = tag_ch;
    end else if (info.prefix[1] && info.pos >= XM_LEN) begin
      if (info.version < XM_MIN_VER) begin
        fmt = FMT_XM_OLD;
      end else begin
        fmt      = FMT_XM;
        channels = info.b68;
      end
    end else if (info.prefix[2] && info.pos >= MXM_MIN) begin
      fmt      = FMT_MXM;
      channels = info.b12;
    end else if (ext_kind == EXT_MOD) begin
      if (info.quality == QUALITY_ALL) begin
        fmt      = FMT_MOD31;
        channels = 8'd4;
      end else if (info.quality == QUALITY_LOW) begin
        fmt      = FMT_MOD15;
        channels = 8'd4;
      end
    end else begin
      fmt      = FMT_UNKNOWN;
      channels = 8'd0;
    end
  end

endmodule

[src/tms_checker.sv]
// ---------------------------------------------------------------------------
// tms_checker
// Port-level checks on the header sniffer results.
// ---------------------------------------------------------------------------
module tms_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);
  import tms_pkg::*;

  logic [3:0] cls;
  logic [7:0] ch;

  assign cls = m_axis_tdata[3:0];
  assign ch  = m_axis_tdata[11:4];

  // stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> cls <= FMT_XM_OLD && m_axis_tdata[15:12] == 4'd0)
    else $error("result class out of range");

  a_no_ch: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (cls == FMT_UNKNOWN || cls == FMT_COMPRESSED ||
                      cls == FMT_WOW || cls == FMT_XM_OLD) |-> ch == 8'd0)
    else $error("channel count set for a class without channels");

  a_guess: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (cls == FMT_MOD31 || cls == FMT_MOD15) |-> ch == 8'd4)
    else $error("scanned mod without four channels");

  a_tag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && cls == FMT_MOD |-> ch >= 8'd1 && ch <= 8'd32)
    else $error("tagged mod channel count out of range");

endmodule

bind tracker_module_header_sniffer tms_checker u_tms_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
